[sv/ttce_pkg.sv]
// Shared types and constants of the text terminal cell engine.
// No dependencies; the interfaces, the cell RAM user and the top level use it.
package ttce_pkg;

    localparam int DEFAULT_MAX_COLUMNS = 64;
    localparam int DEFAULT_MAX_ROWS    = 32;

    localparam int CELL_W     = 16;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int COLCNT_W   = 7;
    localparam int ROWCNT_W   = 6;
    localparam int UCOL_W     = 9;
    localparam int UROW_W     = 8;
    localparam int OUT_ROW_W  = 5;
    localparam int OUT_COL_W  = 6;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;

    localparam logic [COLCNT_W-1:0] RESET_COLUMNS = 7'd64;
    localparam logic [ROWCNT_W-1:0] RESET_ROWS    = 6'd24;
    localparam logic [COLOR_W-1:0]  RESET_FG      = 4'd7;
    localparam logic [COLOR_W-1:0]  RESET_BG      = 4'd0;
    localparam logic [CELL_W-1:0]   RESET_CELL    = {CH_BLANK, RESET_FG, RESET_BG};

    typedef enum logic [1:0] {
        CMD_PUT_CHAR   = 2'd0,
        CMD_SET_CURSOR = 2'd1,
        CMD_CLEAR      = 2'd2,
        CMD_READ_CELL  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLUMN_COUNT = 2'd0,
        REG_ROW_COUNT    = 2'd1,
        REG_FOREGROUND   = 2'd2,
        REG_BACKGROUND   = 2'd3
    } cfg_reg_t;

endpackage

[sv/ttce_if.sv]
// Channel interfaces of the text terminal cell engine: command, result, register write.
// Depends on ttce_pkg for field widths.
interface ttce_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [ttce_pkg::CHAR_W-1:0] char_code;
    logic [7:0] target_row;
    logic [7:0] target_col;

    modport source (output valid, command, char_code, target_row, target_col, input ready);
    modport sink   (input valid, command, char_code, target_row, target_col, output ready);
endinterface

interface ttce_res_if;
    logic valid;
    logic ready;
    logic cell_valid;
    logic [ttce_pkg::OUT_ROW_W-1:0] pos_row;
    logic [ttce_pkg::OUT_COL_W-1:0] pos_col;
    logic [ttce_pkg::CHAR_W-1:0]    cell_char;
    logic [ttce_pkg::COLOR_W-1:0]   cell_fg;
    logic [ttce_pkg::COLOR_W-1:0]   cell_bg;
    logic [ttce_pkg::OUT_ROW_W-1:0] cursor_row_now;
    logic [ttce_pkg::OUT_COL_W-1:0] cursor_col_now;
    logic scrolled;
    logic screen_cleared;

    modport source (output valid, cell_valid, pos_row, pos_col, cell_char, cell_fg, cell_bg,
                    cursor_row_now, cursor_col_now, scrolled, screen_cleared, input ready);
    modport sink   (input valid, cell_valid, pos_row, pos_col, cell_char, cell_fg, cell_bg,
                    cursor_row_now, cursor_col_now, scrolled, screen_cleared, output ready);
endinterface

interface ttce_cfg_if;
    logic valid;
    logic ready;
    logic [ttce_pkg::CFG_IDX_W-1:0]  index;
    logic [ttce_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/ttce_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ttce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/text_terminal_cell_engine.sv]
// Top level of the text terminal cell engine: cursor, command sequencer and cell RAM.
// Depends on ttce_pkg, the ttce_if interfaces and ttce_ram.
//
// Usage:
//   cmd carries one command beat (put_char, set_cursor, clear_screen, read_cell); res
//   returns exactly one result beat per command; cfg writes the column count, row
//   count and the two colors, and is taken only while no command is in work.
//   One sequencer drives a single cell RAM port pair, one cell access per cycle.
//   Each command is registered, worked in an execute step and handed to the output
//   register in a finishing step; read_cell adds a step that waits for the RAM read
//   data. A put_char that scrolls reads then writes each moved cell and then blanks
//   the last row; clear_screen blanks every cell of the rows and columns in use.
//   A new command is taken only when the previous one is finished.
//   After reset the cell RAM is swept to blanks (grey on black), one cell a cycle,
//   all MAX_ROWS*MAX_COLUMNS cells (2048 by default); cmd.ready stays low meanwhile,
//   cfg writes are taken. Results sit in an output register; when res stalls, the
//   next command is still accepted and worked, and its result waits for the slot.
module text_terminal_cell_engine #(
    parameter int MAX_COLUMNS = ttce_pkg::DEFAULT_MAX_COLUMNS,
    parameter int MAX_ROWS    = ttce_pkg::DEFAULT_MAX_ROWS
) (
    input  logic       clk,
    input  logic       rst_n,
    ttce_cmd_if.sink   cmd,
    ttce_res_if.source res,
    ttce_cfg_if.sink   cfg
);

    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RD_WAIT,
        ST_SC_RD,
        ST_SC_WR,
        ST_FILL,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [ttce_pkg::COLCNT_W-1:0] col_count_reg;
    logic [ttce_pkg::ROWCNT_W-1:0] row_count_reg;
    logic [ttce_pkg::COLOR_W-1:0]  fg_reg;
    logic [ttce_pkg::COLOR_W-1:0]  bg_reg;

    logic [ROW_W-1:0]  cur_row_reg;
    logic [COL_W-1:0]  cur_col_reg;
    ttce_pkg::cmd_t    cmd_reg;
    logic [ttce_pkg::CHAR_W-1:0] char_reg;
    logic [7:0]        trow_reg;
    logic [7:0]        tcol_reg;
    logic [ROW_W-1:0]  walk_row_reg;
    logic [COL_W-1:0]  walk_col_reg;
    logic [ADDR_W-1:0] init_addr_reg;

    logic                        res_valid_reg;
    logic [ROW_W-1:0]            res_row_reg;
    logic [COL_W-1:0]            res_col_reg;
    logic [ttce_pkg::CELL_W-1:0] res_cell_reg;
    logic                        res_scrolled_reg;
    logic                        res_cleared_reg;

    logic                            out_valid_reg;
    logic                            out_cell_valid_reg;
    logic [ttce_pkg::OUT_ROW_W-1:0]  out_row_reg;
    logic [ttce_pkg::OUT_COL_W-1:0]  out_col_reg;
    logic [ttce_pkg::CELL_W-1:0]     out_cell_reg;
    logic [ttce_pkg::OUT_ROW_W-1:0]  out_cur_row_reg;
    logic [ttce_pkg::OUT_COL_W-1:0]  out_cur_col_reg;
    logic                            out_scrolled_reg;
    logic                            out_cleared_reg;

    logic [ttce_pkg::UCOL_W-1:0] used_cols;
    logic [ttce_pkg::UROW_W-1:0] used_rows;
    logic [COL_W-1:0]            last_col;
    logic [ROW_W-1:0]            last_row;
    logic [ttce_pkg::CELL_W-1:0] blank_cell;
    logic                        at_last_row;
    logic                        at_last_col;
    logic                        trow_ok;
    logic                        tcol_ok;
    logic                        is_newline;
    logic                        is_return;
    logic                        is_backspace;
    logic                        bs_moved;
    logic [ROW_W-1:0]            bs_row;
    logic [COL_W-1:0]            bs_col;
    logic                        exec_we;
    logic [ROW_W-1:0]            exec_row;
    logic [COL_W-1:0]            exec_col;
    logic [ttce_pkg::CELL_W-1:0] exec_cell;

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [ttce_pkg::CELL_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [ttce_pkg::CELL_W-1:0] ram_rdata;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(row) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(col);
    endfunction

    always_comb
    begin
        if (col_count_reg == '0)
        begin
            used_cols = ttce_pkg::UCOL_W'(1);
        end
        else if (ttce_pkg::UCOL_W'(col_count_reg) > ttce_pkg::UCOL_W'(MAX_COLUMNS))
        begin
            used_cols = ttce_pkg::UCOL_W'(MAX_COLUMNS);
        end
        else
        begin
            used_cols = ttce_pkg::UCOL_W'(col_count_reg);
        end
        if (row_count_reg == '0)
        begin
            used_rows = ttce_pkg::UROW_W'(1);
        end
        else if (ttce_pkg::UROW_W'(row_count_reg) > ttce_pkg::UROW_W'(MAX_ROWS))
        begin
            used_rows = ttce_pkg::UROW_W'(MAX_ROWS);
        end
        else
        begin
            used_rows = ttce_pkg::UROW_W'(row_count_reg);
        end
    end

    assign last_col     = COL_W'(used_cols - ttce_pkg::UCOL_W'(1));
    assign last_row     = ROW_W'(used_rows - ttce_pkg::UROW_W'(1));
    assign blank_cell   = {ttce_pkg::CH_BLANK, fg_reg, bg_reg};
    assign at_last_row  = (cur_row_reg == last_row);
    assign at_last_col  = (cur_col_reg == last_col);
    assign trow_ok      = (ttce_pkg::UROW_W'(trow_reg) < used_rows);
    assign tcol_ok      = (ttce_pkg::UCOL_W'(tcol_reg) < used_cols);
    assign is_newline   = (char_reg == ttce_pkg::CH_NEWLINE);
    assign is_return    = (char_reg == ttce_pkg::CH_RETURN);
    assign is_backspace = (char_reg == ttce_pkg::CH_BACKSPACE);

    always_comb
    begin
        bs_moved = 1'b1;
        bs_row   = cur_row_reg;
        bs_col   = cur_col_reg;
        priority if (cur_col_reg != '0)
        begin
            bs_col = cur_col_reg - COL_W'(1);
        end
        else if (cur_row_reg != '0)
        begin
            bs_row = cur_row_reg - ROW_W'(1);
            bs_col = last_col;
        end
        else
        begin
            bs_moved = 1'b0;
        end
    end

    always_comb
    begin
        exec_we   = 1'b0;
        exec_row  = cur_row_reg;
        exec_col  = cur_col_reg;
        exec_cell = {char_reg, fg_reg, bg_reg};
        if (cmd_reg == ttce_pkg::CMD_PUT_CHAR)
        begin
            priority if (is_newline || is_return)
            begin
                exec_we = 1'b0;
            end
            else if (is_backspace)
            begin
                exec_we   = bs_moved;
                exec_row  = bs_row;
                exec_col  = bs_col;
                exec_cell = blank_cell;
            end
            else
            begin
                exec_we = 1'b1;
            end
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cell_addr(walk_row_reg, walk_col_reg);
        ram_wdata = blank_cell;
        ram_re    = 1'b0;
        ram_raddr = cell_addr(walk_row_reg, walk_col_reg);
        unique case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = init_addr_reg;
                ram_wdata = ttce_pkg::RESET_CELL;
            end
            ST_EXEC:
            begin
                ram_we    = (state_reg == ST_EXEC) && exec_we;
                ram_waddr = cell_addr(exec_row, exec_col);
                ram_wdata = exec_cell;
                ram_re    = (cmd_reg == ttce_pkg::CMD_READ_CELL) && trow_ok && tcol_ok;
                ram_raddr = cell_addr(ROW_W'(trow_reg), COL_W'(tcol_reg));
            end
            ST_SC_RD:
            begin
                ram_re = 1'b1;
            end
            ST_SC_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(walk_row_reg - ROW_W'(1), walk_col_reg);
                ram_wdata = ram_rdata;
            end
            ST_FILL:
            begin
                ram_we = 1'b1;
            end
            ST_IDLE, ST_RD_WAIT, ST_DONE:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    ttce_ram #(
        .WIDTH (ttce_pkg::CELL_W),
        .DEPTH (DEPTH)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cfg.ready = (state_reg == ST_IDLE) || (state_reg == ST_INIT);

    assign res.valid          = out_valid_reg;
    assign res.cell_valid     = out_cell_valid_reg;
    assign res.pos_row        = out_row_reg;
    assign res.pos_col        = out_col_reg;
    assign res.cell_char      = out_cell_reg[15:8];
    assign res.cell_fg        = out_cell_reg[7:4];
    assign res.cell_bg        = out_cell_reg[3:0];
    assign res.cursor_row_now = out_cur_row_reg;
    assign res.cursor_col_now = out_cur_col_reg;
    assign res.scrolled       = out_scrolled_reg;
    assign res.screen_cleared = out_cleared_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_INIT;
            col_count_reg      <= ttce_pkg::RESET_COLUMNS;
            row_count_reg      <= ttce_pkg::RESET_ROWS;
            fg_reg             <= ttce_pkg::RESET_FG;
            bg_reg             <= ttce_pkg::RESET_BG;
            cur_row_reg        <= '0;
            cur_col_reg        <= '0;
            init_addr_reg      <= '0;
            out_valid_reg      <= 1'b0;
            cmd_reg            <= ttce_pkg::CMD_PUT_CHAR;
            char_reg           <= '0;
            trow_reg           <= '0;
            tcol_reg           <= '0;
            walk_row_reg       <= '0;
            walk_col_reg       <= '0;
            res_valid_reg      <= 1'b0;
            res_row_reg        <= '0;
            res_col_reg        <= '0;
            res_cell_reg       <= '0;
            res_scrolled_reg   <= 1'b0;
            res_cleared_reg    <= 1'b0;
            out_cell_valid_reg <= 1'b0;
            out_row_reg        <= '0;
            out_col_reg        <= '0;
            out_cell_reg       <= '0;
            out_cur_row_reg    <= '0;
            out_cur_col_reg    <= '0;
            out_scrolled_reg   <= 1'b0;
            out_cleared_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (ttce_pkg::cfg_reg_t'(cfg.index))
                    ttce_pkg::REG_COLUMN_COUNT: col_count_reg <= cfg.data;
                    ttce_pkg::REG_ROW_COUNT:    row_count_reg <= cfg.data[ttce_pkg::ROWCNT_W-1:0];
                    ttce_pkg::REG_FOREGROUND:   fg_reg        <= cfg.data[ttce_pkg::COLOR_W-1:0];
                    ttce_pkg::REG_BACKGROUND:   bg_reg        <= cfg.data[ttce_pkg::COLOR_W-1:0];
                    default:                    fg_reg        <= fg_reg;
                endcase
            end

            if (res.ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_INIT:
                begin
                    init_addr_reg <= init_addr_reg + ADDR_W'(1);
                    if (init_addr_reg == ADDR_W'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        cmd_reg          <= ttce_pkg::cmd_t'(cmd.command);
                        char_reg         <= cmd.char_code;
                        trow_reg         <= cmd.target_row;
                        tcol_reg         <= cmd.target_col;
                        res_valid_reg    <= 1'b0;
                        res_row_reg      <= '0;
                        res_col_reg      <= '0;
                        res_cell_reg     <= '0;
                        res_scrolled_reg <= 1'b0;
                        res_cleared_reg  <= 1'b0;
                        if (ttce_pkg::UROW_W'(cur_row_reg) >= used_rows)
                        begin
                            cur_row_reg <= last_row;
                        end
                        if (ttce_pkg::UCOL_W'(cur_col_reg) >= used_cols)
                        begin
                            cur_col_reg <= last_col;
                        end
                        state_reg <= ST_EXEC;
                    end
                end

                ST_EXEC:
                begin
                    if (exec_we)
                    begin
                        res_valid_reg <= 1'b1;
                        res_row_reg   <= exec_row;
                        res_col_reg   <= exec_col;
                        res_cell_reg  <= exec_cell;
                    end
                    unique case (cmd_reg)
                        ttce_pkg::CMD_PUT_CHAR:
                        begin
                            priority if (is_return)
                            begin
                                cur_col_reg <= '0;
                                state_reg   <= ST_DONE;
                            end
                            else if (is_backspace)
                            begin
                                cur_row_reg <= bs_row;
                                cur_col_reg <= bs_col;
                                state_reg   <= ST_DONE;
                            end
                            else if (is_newline || at_last_col)
                            begin
                                cur_col_reg <= '0;
                                if (at_last_row)
                                begin
                                    res_scrolled_reg <= 1'b1;
                                    walk_col_reg     <= '0;
                                    if (last_row == '0)
                                    begin
                                        walk_row_reg <= last_row;
                                        state_reg    <= ST_FILL;
                                    end
                                    else
                                    begin
                                        walk_row_reg <= ROW_W'(1);
                                        state_reg    <= ST_SC_RD;
                                    end
                                end
                                else
                                begin
                                    cur_row_reg <= cur_row_reg + ROW_W'(1);
                                    state_reg   <= ST_DONE;
                                end
                            end
                            else
                            begin
                                cur_col_reg <= cur_col_reg + COL_W'(1);
                                state_reg   <= ST_DONE;
                            end
                        end
                        ttce_pkg::CMD_SET_CURSOR:
                        begin
                            if (trow_ok)
                            begin
                                cur_row_reg <= ROW_W'(trow_reg);
                            end
                            if (tcol_ok)
                            begin
                                cur_col_reg <= COL_W'(tcol_reg);
                            end
                            state_reg <= ST_DONE;
                        end
                        ttce_pkg::CMD_CLEAR:
                        begin
                            cur_row_reg     <= '0;
                            cur_col_reg     <= '0;
                            res_cleared_reg <= 1'b1;
                            walk_row_reg    <= '0;
                            walk_col_reg    <= '0;
                            state_reg       <= ST_FILL;
                        end
                        ttce_pkg::CMD_READ_CELL:
                        begin
                            if (trow_ok && tcol_ok)
                            begin
                                res_valid_reg <= 1'b1;
                                res_row_reg   <= ROW_W'(trow_reg);
                                res_col_reg   <= COL_W'(tcol_reg);
                                state_reg     <= ST_RD_WAIT;
                            end
                            else
                            begin
                                state_reg <= ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_reg <= ST_DONE;
                        end
                    endcase
                end

                ST_RD_WAIT:
                begin
                    res_cell_reg <= ram_rdata;
                    state_reg    <= ST_DONE;
                end

                ST_SC_RD:
                begin
                    state_reg <= ST_SC_WR;
                end

                ST_SC_WR:
                begin
                    if (walk_col_reg == last_col)
                    begin
                        walk_col_reg <= '0;
                        if (walk_row_reg == last_row)
                        begin
                            state_reg <= ST_FILL;
                        end
                        else
                        begin
                            walk_row_reg <= walk_row_reg + ROW_W'(1);
                            state_reg    <= ST_SC_RD;
                        end
                    end
                    else
                    begin
                        walk_col_reg <= walk_col_reg + COL_W'(1);
                        state_reg    <= ST_SC_RD;
                    end
                end

                ST_FILL:
                begin
                    if (walk_col_reg == last_col)
                    begin
                        walk_col_reg <= '0;
                        if (walk_row_reg == last_row)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            walk_row_reg <= walk_row_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        walk_col_reg <= walk_col_reg + COL_W'(1);
                    end
                end

                ST_DONE:
                begin
                    if (!out_valid_reg || res.ready)
                    begin
                        out_valid_reg      <= 1'b1;
                        out_cell_valid_reg <= res_valid_reg;
                        out_row_reg        <= ttce_pkg::OUT_ROW_W'(res_row_reg);
                        out_col_reg        <= ttce_pkg::OUT_COL_W'(res_col_reg);
                        out_cell_reg       <= res_cell_reg;
                        out_cur_row_reg    <= ttce_pkg::OUT_ROW_W'(cur_row_reg);
                        out_cur_col_reg    <= ttce_pkg::OUT_COL_W'(cur_col_reg);
                        out_scrolled_reg   <= res_scrolled_reg;
                        out_cleared_reg    <= res_cleared_reg;
                        state_reg          <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside the finishing step");

    a_cursor_in_area: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (ttce_pkg::UROW_W'(cur_row_reg) < used_rows) &&
                                   (ttce_pkg::UCOL_W'(cur_col_reg) < used_cols))
        else $error("cursor left the area in use");

    a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && res_scrolled_reg) |-> (cur_row_reg == last_row) &&
                                                       (cur_col_reg == '0))
        else $error("scroll did not park cursor at start of last row");

    a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && res_cleared_reg) |-> (cur_row_reg == '0) &&
                                                      (cur_col_reg == '0) && !res_valid_reg)
        else $error("clear left cursor away from origin");

    a_no_cmd_during_init: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT) |=> (state_reg == ST_INIT) || (state_reg == ST_IDLE))
        else $error("sweep after reset interrupted");

endmodule

[verif/ttce_cell_checker.sv]
// Scoreboard for the text terminal cell engine: shadows the cell grid, cursor and registers,
// predicts one result beat per command beat and compares the result channel field by field.
// Depends on ttce_pkg and the ttce_if interfaces.
`timescale 1ns / 100ps

module ttce_cell_checker (
    input  logic  clk,
    input  logic  rst_n,
    ttce_cmd_if   cmd_mon,
    ttce_res_if   res_mon,
    ttce_cfg_if   cfg_mon,
    output int    mismatch_count,
    output int    awaiting
);

    localparam int GRID_COLS = ttce_pkg::DEFAULT_MAX_COLUMNS;
    localparam int GRID_ROWS = ttce_pkg::DEFAULT_MAX_ROWS;

    typedef struct packed {
        logic                           cell_valid;
        logic [ttce_pkg::OUT_ROW_W-1:0] pos_row;
        logic [ttce_pkg::OUT_COL_W-1:0] pos_col;
        logic [ttce_pkg::CHAR_W-1:0]    cell_char;
        logic [ttce_pkg::COLOR_W-1:0]   cell_fg;
        logic [ttce_pkg::COLOR_W-1:0]   cell_bg;
        logic [ttce_pkg::OUT_ROW_W-1:0] cursor_row_now;
        logic [ttce_pkg::OUT_COL_W-1:0] cursor_col_now;
        logic                           scrolled;
        logic                           screen_cleared;
    } cell_result_t;

    logic [ttce_pkg::CELL_W-1:0]   grid [0:GRID_ROWS*GRID_COLS-1];
    int unsigned                   cursor_row;
    int unsigned                   cursor_col;
    logic [ttce_pkg::COLCNT_W-1:0] column_count;
    logic [ttce_pkg::ROWCNT_W-1:0] row_count;
    logic [ttce_pkg::COLOR_W-1:0]  fg_color;
    logic [ttce_pkg::COLOR_W-1:0]  bg_color;
    cell_result_t                  expected_cells [$];

    function automatic logic [ttce_pkg::CELL_W-1:0] paint(input logic [ttce_pkg::CHAR_W-1:0] ch);
        return {ch, fg_color, bg_color};
    endfunction

    task automatic scroll_grid(input int unsigned rows, input int unsigned cols);
        for (int r = 1; r < rows; r++)
            for (int c = 0; c < cols; c++)
                grid[(r-1)*GRID_COLS + c] = grid[r*GRID_COLS + c];
        for (int c = 0; c < cols; c++)
            grid[(rows-1)*GRID_COLS + c] = paint(ttce_pkg::CH_BLANK);
    endtask

    task automatic apply_terminal_command(input ttce_pkg::cmd_t op, input logic [7:0] ch,
                                          input logic [7:0] trow, input logic [7:0] tcol,
                                          output cell_result_t want);
        int unsigned rows;
        int unsigned cols;
        int unsigned hit_row;
        int unsigned hit_col;
        logic [ttce_pkg::CELL_W-1:0] touched;
        bit moved;
        want = '0;
        touched = '0;
        hit_row = 0;
        hit_col = 0;
        rows = (row_count == 0) ? 1 : ((row_count > GRID_ROWS) ? GRID_ROWS : row_count);
        cols = (column_count == 0) ? 1 :
               ((column_count > GRID_COLS) ? GRID_COLS : column_count);
        if (cursor_row >= rows) cursor_row = rows - 1;
        if (cursor_col >= cols) cursor_col = cols - 1;
        case (op)
            ttce_pkg::CMD_PUT_CHAR: begin
                if (ch == ttce_pkg::CH_NEWLINE) begin
                    cursor_col = 0;
                    cursor_row++;
                end else if (ch == ttce_pkg::CH_RETURN) begin
                    cursor_col = 0;
                end else if (ch == ttce_pkg::CH_BACKSPACE) begin
                    moved = 1'b1;
                    if (cursor_col > 0) begin
                        cursor_col--;
                    end else if (cursor_row > 0) begin
                        cursor_row--;
                        cursor_col = cols - 1;
                    end else begin
                        moved = 1'b0;
                    end
                    if (moved) begin
                        touched = paint(ttce_pkg::CH_BLANK);
                        grid[cursor_row*GRID_COLS + cursor_col] = touched;
                        want.cell_valid = 1'b1;
                        hit_row = cursor_row;
                        hit_col = cursor_col;
                    end
                end else begin
                    touched = paint(ch);
                    grid[cursor_row*GRID_COLS + cursor_col] = touched;
                    want.cell_valid = 1'b1;
                    hit_row = cursor_row;
                    hit_col = cursor_col;
                    cursor_col++;
                    if (cursor_col >= cols) begin
                        cursor_col = 0;
                        cursor_row++;
                    end
                end
                if (cursor_row >= rows) begin
                    scroll_grid(rows, cols);
                    cursor_row = rows - 1;
                    want.scrolled = 1'b1;
                end
            end
            ttce_pkg::CMD_SET_CURSOR: begin
                if (trow < rows) cursor_row = trow;
                if (tcol < cols) cursor_col = tcol;
            end
            ttce_pkg::CMD_CLEAR: begin
                for (int r = 0; r < rows; r++)
                    for (int c = 0; c < cols; c++)
                        grid[r*GRID_COLS + c] = paint(ttce_pkg::CH_BLANK);
                cursor_row = 0;
                cursor_col = 0;
                want.screen_cleared = 1'b1;
            end
            default: begin
                if (trow < rows && tcol < cols) begin
                    want.cell_valid = 1'b1;
                    hit_row = trow;
                    hit_col = tcol;
                    touched = grid[trow*GRID_COLS + tcol];
                end
            end
        endcase
        want.pos_row = ttce_pkg::OUT_ROW_W'(hit_row);
        want.pos_col = ttce_pkg::OUT_COL_W'(hit_col);
        want.cell_char = touched[ttce_pkg::CELL_W-1 -: ttce_pkg::CHAR_W];
        want.cell_fg = touched[2*ttce_pkg::COLOR_W-1 -: ttce_pkg::COLOR_W];
        want.cell_bg = touched[ttce_pkg::COLOR_W-1:0];
        want.cursor_row_now = ttce_pkg::OUT_ROW_W'(cursor_row);
        want.cursor_col_now = ttce_pkg::OUT_COL_W'(cursor_col);
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t %s: expected %0h actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        cell_result_t want;
        if (!rst_n) begin
            column_count = ttce_pkg::RESET_COLUMNS;
            row_count = ttce_pkg::RESET_ROWS;
            fg_color = ttce_pkg::RESET_FG;
            bg_color = ttce_pkg::RESET_BG;
            for (int i = 0; i < GRID_ROWS*GRID_COLS; i++)
                grid[i] = paint(ttce_pkg::CH_BLANK);
            cursor_row = 0;
            cursor_col = 0;
            expected_cells.delete();
            mismatch_count = 0;
            awaiting <= 0;
        end else begin
            if (cfg_mon.valid && cfg_mon.ready) begin
                case (ttce_pkg::cfg_reg_t'(cfg_mon.index))
                    ttce_pkg::REG_COLUMN_COUNT:
                        column_count = cfg_mon.data[ttce_pkg::COLCNT_W-1:0];
                    ttce_pkg::REG_ROW_COUNT:
                        row_count = cfg_mon.data[ttce_pkg::ROWCNT_W-1:0];
                    ttce_pkg::REG_FOREGROUND:
                        fg_color = cfg_mon.data[ttce_pkg::COLOR_W-1:0];
                    default:
                        bg_color = cfg_mon.data[ttce_pkg::COLOR_W-1:0];
                endcase
            end
            if (cmd_mon.valid && cmd_mon.ready) begin
                apply_terminal_command(ttce_pkg::cmd_t'(cmd_mon.command), cmd_mon.char_code,
                                       cmd_mon.target_row, cmd_mon.target_col, want);
                expected_cells.push_back(want);
            end
            if (res_mon.valid && res_mon.ready) begin
                if (expected_cells.size() == 0) begin
                    mismatch_count++;
                    $display("%0t result beat: expected none actual cursor %0h,%0h", $time,
                             res_mon.cursor_row_now, res_mon.cursor_col_now);
                end else begin
                    want = expected_cells.pop_front();
                    check_field("cell_valid", 16'(want.cell_valid), 16'(res_mon.cell_valid));
                    check_field("pos_row", 16'(want.pos_row), 16'(res_mon.pos_row));
                    check_field("pos_col", 16'(want.pos_col), 16'(res_mon.pos_col));
                    check_field("cell_char", 16'(want.cell_char), 16'(res_mon.cell_char));
                    check_field("cell_fg", 16'(want.cell_fg), 16'(res_mon.cell_fg));
                    check_field("cell_bg", 16'(want.cell_bg), 16'(res_mon.cell_bg));
                    check_field("cursor_row_now", 16'(want.cursor_row_now),
                                16'(res_mon.cursor_row_now));
                    check_field("cursor_col_now", 16'(want.cursor_col_now),
                                16'(res_mon.cursor_col_now));
                    check_field("scrolled", 16'(want.scrolled), 16'(res_mon.scrolled));
                    check_field("screen_cleared", 16'(want.screen_cleared),
                                16'(res_mon.screen_cleared));
                end
            end
            awaiting <= expected_cells.size();
        end
    end

endmodule

[verif/text_terminal_cell_engine_tb.sv]
// Top of the text terminal cell engine testbench: clock, reset, command and register stimulus,
// result-side backpressure and the verdict. Depends on ttce_pkg, the ttce_if interfaces,
// the engine itself and ttce_cell_checker.
`timescale 1ns / 100ps

module text_terminal_cell_engine_tb;

    localparam int TOTAL_ITEMS = 1450;
    localparam int STALL_LIMIT = 50000;

    logic clk = 1'b0;
    logic rst_n;

    ttce_cmd_if cmd_if ();
    ttce_res_if res_if ();
    ttce_cfg_if cfg_if ();

    int          mismatch_count;
    int          awaiting;
    int          items_sent;
    int          results_taken;
    bit          send_back_to_back;
    bit          take_back_to_back;
    int unsigned cols_in_use;
    int unsigned rows_in_use;

    always #10 clk = ~clk;

    text_terminal_cell_engine DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    ttce_cell_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_mon        (cmd_if),
        .res_mon        (res_if),
        .cfg_mon        (cfg_if),
        .mismatch_count (mismatch_count),
        .awaiting       (awaiting)
    );

    task automatic send_command(input ttce_pkg::cmd_t op, input logic [7:0] ch,
                                input logic [7:0] trow, input logic [7:0] tcol);
        int gap;
        gap = send_back_to_back ? 0 : $urandom_range(0, 4);
        repeat (gap)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.command <= op;
        cmd_if.char_code <= ch;
        cmd_if.target_row <= trow;
        cmd_if.target_col <= tcol;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic write_register(input ttce_pkg::cfg_reg_t idx,
                                  input logic [ttce_pkg::CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
    endtask

    task automatic drain_results;
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0) @(posedge clk);
    endtask

    task automatic send_random_item;
        int unsigned pick;
        int unsigned sel;
        logic [7:0] ch;
        logic [7:0] trow;
        logic [7:0] tcol;
        pick = $urandom_range(0, 99);
        ch = 8'($urandom_range(0, 255));
        trow = 8'($urandom_range(0, 255));
        tcol = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0)
        begin
            trow = 8'($urandom_range(0, rows_in_use));
            tcol = 8'($urandom_range(0, cols_in_use));
        end
        if (pick < 60)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 12)
                ch = ttce_pkg::CH_NEWLINE;
            else if (sel < 18)
                ch = ttce_pkg::CH_RETURN;
            else if (sel < 30)
                ch = ttce_pkg::CH_BACKSPACE;
            send_command(ttce_pkg::CMD_PUT_CHAR, ch, trow, tcol);
        end
        else if (pick < 72)
            send_command(ttce_pkg::CMD_SET_CURSOR, ch, trow, tcol);
        else if (pick < 75)
            send_command(ttce_pkg::CMD_CLEAR, ch, trow, tcol);
        else
            send_command(ttce_pkg::CMD_READ_CELL, ch, trow, tcol);
    endtask

    initial
    begin
        int unsigned cols_cfg;
        int unsigned rows_cfg;
        int unsigned fg_cfg;
        int unsigned bg_cfg;
        int          burst;
        bit          wide;
        rst_n = 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.command <= ttce_pkg::CMD_PUT_CHAR;
        cmd_if.char_code <= '0;
        cmd_if.target_row <= '0;
        cmd_if.target_col <= '0;
        res_if.ready <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= ttce_pkg::REG_COLUMN_COUNT;
        cfg_if.data <= '0;
        items_sent = 0;
        send_back_to_back = 1'b0;
        take_back_to_back = 1'b0;
        cols_in_use = ttce_pkg::RESET_COLUMNS;
        rows_in_use = ttce_pkg::RESET_ROWS;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_command(ttce_pkg::CMD_READ_CELL, 8'd0, 8'd0, 8'd0);
        send_command(ttce_pkg::CMD_PUT_CHAR, ttce_pkg::CH_BACKSPACE, 8'd0, 8'd0);
        send_command(ttce_pkg::CMD_PUT_CHAR, 8'h41, 8'd0, 8'd0);
        send_command(ttce_pkg::CMD_PUT_CHAR, 8'h00, 8'd0, 8'd0);
        send_command(ttce_pkg::CMD_PUT_CHAR, 8'hFF, 8'd0, 8'd0);
        send_command(ttce_pkg::CMD_PUT_CHAR, ttce_pkg::CH_BACKSPACE, 8'd0, 8'd0);
        send_command(ttce_pkg::CMD_PUT_CHAR, ttce_pkg::CH_RETURN, 8'd0, 8'd0);
        send_command(ttce_pkg::CMD_PUT_CHAR, ttce_pkg::CH_NEWLINE, 8'd0, 8'd0);
        send_command(ttce_pkg::CMD_SET_CURSOR, 8'd0, 8'd23, 8'd63);
        send_command(ttce_pkg::CMD_PUT_CHAR, 8'h5A, 8'd0, 8'd0);
        send_command(ttce_pkg::CMD_READ_CELL, 8'd0, 8'd22, 8'd63);
        send_command(ttce_pkg::CMD_SET_CURSOR, 8'd0, 8'd255, 8'd255);
        send_command(ttce_pkg::CMD_SET_CURSOR, 8'd0, 8'd5, 8'd200);
        send_command(ttce_pkg::CMD_SET_CURSOR, 8'd0, 8'd200, 8'd7);
        send_command(ttce_pkg::CMD_SET_CURSOR, 8'd0, 8'd3, 8'd0);
        send_command(ttce_pkg::CMD_PUT_CHAR, ttce_pkg::CH_BACKSPACE, 8'd0, 8'd0);
        send_command(ttce_pkg::CMD_READ_CELL, 8'd0, 8'd2, 8'd63);
        send_command(ttce_pkg::CMD_READ_CELL, 8'd0, 8'd255, 8'd0);
        send_command(ttce_pkg::CMD_READ_CELL, 8'd0, 8'd0, 8'd255);
        send_command(ttce_pkg::CMD_READ_CELL, 8'd0, 8'd24, 8'd0);
        send_command(ttce_pkg::CMD_SET_CURSOR, 8'd0, 8'd23, 8'd0);
        send_command(ttce_pkg::CMD_PUT_CHAR, ttce_pkg::CH_NEWLINE, 8'd0, 8'd0);
        send_command(ttce_pkg::CMD_CLEAR, 8'd0, 8'd0, 8'd0);
        send_command(ttce_pkg::CMD_READ_CELL, 8'd0, 8'd0, 8'd0);

        for (int phase = 0; items_sent < TOTAL_ITEMS; phase++)
        begin
            drain_results();
            wide = 1'b0;
            fg_cfg = $urandom_range(0, 15);
            bg_cfg = $urandom_range(0, 15);
            case (phase)
                0: begin cols_cfg = 1; rows_cfg = 1; fg_cfg = 15; bg_cfg = 15; end
                1: begin cols_cfg = 0; rows_cfg = 0; fg_cfg = 0; bg_cfg = 0; end
                2: begin cols_cfg = 64; rows_cfg = 32; fg_cfg = 15; bg_cfg = 0; wide = 1'b1; end
                3: begin cols_cfg = 127; rows_cfg = 63; fg_cfg = 0; bg_cfg = 15; wide = 1'b1; end
                4: begin cols_cfg = 65; rows_cfg = 33; wide = 1'b1; end
                5: begin cols_cfg = 64; rows_cfg = 1; end
                6: begin cols_cfg = 1; rows_cfg = 32; end
                7: begin cols_cfg = 2; rows_cfg = 2; end
                default:
                begin
                    wide = ($urandom_range(0, 7) == 0);
                    cols_cfg = wide ? $urandom_range(0, 127) : $urandom_range(0, 12);
                    rows_cfg = wide ? $urandom_range(0, 63) : $urandom_range(0, 6);
                end
            endcase
            write_register(ttce_pkg::REG_COLUMN_COUNT, ttce_pkg::CFG_DATA_W'(cols_cfg));
            write_register(ttce_pkg::REG_ROW_COUNT, ttce_pkg::CFG_DATA_W'(rows_cfg));
            write_register(ttce_pkg::REG_FOREGROUND, ttce_pkg::CFG_DATA_W'(fg_cfg));
            write_register(ttce_pkg::REG_BACKGROUND, ttce_pkg::CFG_DATA_W'(bg_cfg));
            cfg_if.valid <= 1'b0;
            cols_in_use = (cols_cfg == 0) ? 1 : ((cols_cfg > 64) ? 64 : cols_cfg);
            rows_in_use = (rows_cfg == 0) ? 1 : ((rows_cfg > 32) ? 32 : rows_cfg);
            send_back_to_back = ($urandom_range(0, 3) == 0);
            take_back_to_back = ($urandom_range(0, 3) == 0);
            burst = wide ? 20 : 60;
            repeat (burst) send_random_item();
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        int stall;
        results_taken = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (results_taken == 150 || results_taken == 700)
                stall = 300;
            else if (take_back_to_back)
                stall = 0;
            else
                stall = $urandom_range(0, 4);
            repeat (stall)
            begin
                res_if.ready <= 1'b0;
                @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid) @(posedge clk);
            results_taken++;
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
sv/ttce_pkg.sv
sv/ttce_if.sv
sv/ttce_ram.sv
sv/text_terminal_cell_engine.sv
verif/ttce_cell_checker.sv
verif/text_terminal_cell_engine_tb.sv
